// ===== rtl/core/pbfl_pkg.sv =====
package pbfl_pkg;

	localparam int BUFFERS = 16;
	localparam int QUEUES  = 4;

	localparam int KIND_W   = 2;
	localparam int BUFFER_W = 4;
	localparam int QSEL_W   = 2;
	localparam int COUNT_W  = 5;

	// link values run 0..BUFFERS, BUFFERS is the null link
	localparam int LW  = $clog2(BUFFERS + 1);
	localparam int LAW = $clog2(BUFFERS);
	localparam int QW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;

	localparam int BCMP_W = ((LW > BUFFER_W) ? LW : BUFFER_W) + 1;
	localparam int QCMP_W = $clog2(QUEUES + 1) + QSEL_W;

	localparam logic [LW-1:0] NULL_LINK = LW'(BUFFERS);

	typedef enum logic [KIND_W-1:0] {
		K_ACQUIRE = 2'd0,
		K_RELEASE = 2'd1,
		K_ENQUEUE = 2'd2,
		K_DEQUEUE = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t           kind;
		logic [LW-1:0]   bidx;
		logic            bidx_ok;
		logic [QW-1:0]   qidx;
		logic            qidx_ok;
	} cmd_t;

endpackage

// ===== rtl/core/pbfl_req_if.sv =====
interface pbfl_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [3:0] buffer;
	logic [1:0] queue_sel;

	modport source (output valid, output kind, output buffer, output queue_sel, input ready);
	modport sink (input valid, input kind, input buffer, input queue_sel, output ready);
endinterface

interface pbfl_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] buffer_out;
	logic       success;
	logic [4:0] queue_count;

	modport source (output valid, output buffer_out, output success, output queue_count,
		input ready);
	modport sink (input valid, input buffer_out, input success, input queue_count,
		output ready);
endinterface

// ===== rtl/core/pbfl_ram.sv =====
module pbfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/pbfl_front.sv =====
module pbfl_front import pbfl_pkg::*; (
	pbfl_req_if.sink req,
	input  logic     clearing,
	input  logic     full,
	output logic     push,
	output cmd_t     push_cmd
);

	assign req.ready = !clearing && !full;
	assign push      = req.valid && req.ready;

	always_comb begin
		push_cmd.kind    = kind_t'(req.kind);
		push_cmd.bidx    = LW'(req.buffer);
		push_cmd.bidx_ok = BCMP_W'(req.buffer) < BCMP_W'(BUFFERS);
		push_cmd.qidx    = QW'(req.queue_sel);
		push_cmd.qidx_ok = QCMP_W'(req.queue_sel) < QCMP_W'(QUEUES);
	end

endmodule

// ===== rtl/core/pbfl_cmd_fifo.sv =====
module pbfl_cmd_fifo import pbfl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/core/pbfl_back.sv =====
module pbfl_back import pbfl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      empty,
	input  cmd_t      head,
	output logic      pop,
	output logic      clearing,
	pbfl_rsp_if.source rsp
);

	localparam int CLR_N = (BUFFERS > QUEUES) ? BUFFERS : QUEUES;
	localparam int CLW   = $clog2(CLR_N);

	typedef struct packed {
		logic [LW-1:0] oldest;
		logic [LW-1:0] newest;
		logic [LW-1:0] entries;
	} qstate_t;

	localparam int QSW = $bits(qstate_t);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_LOOK = 3'b010,
		S_DONE = 3'b100
	} state_t;

	function automatic logic is_buf(input logic [LW-1:0] v);
		return v < NULL_LINK;
	endfunction

	state_t         state_q;
	logic           clearing_q;
	logic [CLW-1:0] clr_q;
	cmd_t           cmd_q;
	logic [LW-1:0]  free_top_q;

	logic               out_valid_q;
	logic [BUFFER_W-1:0] out_buf_q;
	logic               out_ok_q;
	logic [COUNT_W-1:0] out_cnt_q;

	logic           l_we, l_re;
	logic [LAW-1:0] l_waddr, l_raddr;
	logic [LW-1:0]  l_wdata, l_rdata;
	logic           q_we, q_re;
	logic [QW-1:0]  q_waddr, q_raddr;
	qstate_t        q_wdata;
	logic [QSW-1:0] q_rdata;

	qstate_t       qs, qs_next;
	logic          ft_ok, od_ok, nw_ok;
	logic          clr_in_buf, clr_in_q;
	logic          commit;
	logic [LW-1:0] got, ft_next, cnt;
	logic          ok, q_upd;

	pbfl_ram #(.WIDTH(LW), .DEPTH(BUFFERS)) u_link_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.re    (l_re),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	pbfl_ram #(.WIDTH(QSW), .DEPTH(QUEUES)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.re    (q_re),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	assign clearing   = clearing_q;
	assign qs         = qstate_t'(q_rdata);
	assign ft_ok      = is_buf(free_top_q);
	assign od_ok      = is_buf(qs.oldest);
	assign nw_ok      = is_buf(qs.newest);
	assign clr_in_buf = {1'b0, clr_q} < (CLW + 1)'(BUFFERS);
	assign clr_in_q   = {1'b0, clr_q} < (CLW + 1)'(QUEUES);
	assign pop        = (state_q == S_IDLE) && !clearing_q && !empty;
	assign commit     = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	// operation result, valid while in S_DONE
	always_comb begin
		got     = '0;
		ok      = 1'b0;
		ft_next = free_top_q;
		qs_next = qs;
		q_upd   = 1'b0;
		case (cmd_q.kind)
			K_ACQUIRE: begin
				if (ft_ok) begin
					got     = free_top_q;
					ok      = 1'b1;
					ft_next = l_rdata;
				end
			end
			K_RELEASE: begin
				if (cmd_q.bidx_ok) begin
					ok      = 1'b1;
					ft_next = cmd_q.bidx;
				end
			end
			K_ENQUEUE: begin
				if (cmd_q.bidx_ok && cmd_q.qidx_ok) begin
					ok             = 1'b1;
					q_upd          = 1'b1;
					qs_next.newest = cmd_q.bidx;
					if (!nw_ok) begin
						qs_next.oldest = cmd_q.bidx;
					end
					if (qs.entries < NULL_LINK) begin
						qs_next.entries = qs.entries + LW'(1);
					end
				end
			end
			default: begin
				if (cmd_q.qidx_ok && od_ok) begin
					got   = qs.oldest;
					ok    = 1'b1;
					q_upd = 1'b1;
					if (qs.oldest != qs.newest) begin
						qs_next.oldest = l_rdata;
					end else begin
						qs_next.oldest = NULL_LINK;
						qs_next.newest = NULL_LINK;
					end
					if (qs.entries != '0) begin
						qs_next.entries = qs.entries - LW'(1);
					end
				end
			end
		endcase
		cnt = cmd_q.qidx_ok ? qs_next.entries : '0;
	end

	// memory ports
	always_comb begin
		l_re    = 1'b0;
		l_raddr = '0;
		q_re    = 1'b0;
		q_raddr = '0;
		if (pop) begin
			q_re    = 1'b1;
			q_raddr = head.qidx;
			if (head.kind == K_ACQUIRE && ft_ok) begin
				l_re    = 1'b1;
				l_raddr = LAW'(free_top_q);
			end
		end else if (state_q == S_LOOK && cmd_q.kind == K_DEQUEUE && cmd_q.qidx_ok && od_ok)
		begin
			l_re    = 1'b1;
			l_raddr = LAW'(qs.oldest);
		end

		l_we    = 1'b0;
		l_waddr = '0;
		l_wdata = NULL_LINK;
		q_we    = 1'b0;
		q_waddr = '0;
		q_wdata = qs_next;
		if (clearing_q) begin
			l_we    = clr_in_buf;
			l_waddr = LAW'(clr_q);
			l_wdata = LW'(clr_q) + LW'(1);
			q_we    = clr_in_q;
			q_waddr = QW'(clr_q);
			q_wdata = '{oldest: NULL_LINK, newest: NULL_LINK, entries: '0};
		end else if (state_q == S_LOOK) begin
			// enqueue terminates the new buffer first, the old newest is linked at commit
			if (cmd_q.kind == K_ENQUEUE && cmd_q.bidx_ok && cmd_q.qidx_ok) begin
				l_we    = 1'b1;
				l_waddr = LAW'(cmd_q.bidx);
			end
		end else if (commit) begin
			q_we    = q_upd;
			q_waddr = cmd_q.qidx;
			case (cmd_q.kind)
				K_RELEASE: begin
					l_we    = cmd_q.bidx_ok;
					l_waddr = LAW'(cmd_q.bidx);
					l_wdata = free_top_q;
				end
				K_ENQUEUE: begin
					l_we    = cmd_q.bidx_ok && cmd_q.qidx_ok && nw_ok;
					l_waddr = LAW'(qs.newest);
					l_wdata = cmd_q.bidx;
				end
				K_DEQUEUE: begin
					l_we    = cmd_q.qidx_ok && od_ok;
					l_waddr = LAW'(qs.oldest);
				end
				default: begin
					l_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (commit) begin
			out_buf_q <= BUFFER_W'(got);
			out_ok_q  <= ok;
			out_cnt_q <= COUNT_W'(cnt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clearing_q  <= 1'b1;
			clr_q       <= '0;
			free_top_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				if (clr_q == CLW'(CLR_N - 1)) begin
					clearing_q <= 1'b0;
				end else begin
					clr_q <= clr_q + CLW'(1);
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (commit) begin
						state_q    <= S_IDLE;
						free_top_q <= ft_next;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.buffer_out  = out_buf_q;
	assign rsp.success     = out_ok_q;
	assign rsp.queue_count = out_cnt_q;

endmodule

// ===== rtl/core/packet_buffer_free_list_and_queues_top.sv =====
// channel  dir  payload
// req      in   kind[1:0], buffer[3:0], queue_sel[1:0]
// rsp      out  buffer_out[3:0], success, queue_count[4:0]
//
// the back sequencer takes each item through queue-state read, link lookup and commit,
// as set by the registered link and queue-state memory read ports, one item at a time
// after reset a clearing pass over max(BUFFERS, QUEUES) entries, 16 here, holds req.ready low
// a two-entry command queue keeps req flowing while the back part works or waits
// a stalled rsp holds the back part in its commit cycle; the result register parts the sides
module packet_buffer_free_list_and_queues_top import pbfl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pbfl_req_if.sink   req,
	pbfl_rsp_if.source rsp
);

	logic push, full, pop, empty, clearing;
	cmd_t push_cmd, head;

	pbfl_front u_front (
		.req      (req),
		.clearing (clearing),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	pbfl_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	pbfl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.head     (head),
		.pop      (pop),
		.clearing (clearing),
		.rsp      (rsp)
	);

endmodule
